[src/genetic_mutation_engine_assert.svh]
// assertion macros for the mutation engine
// expects aclk and aresetn in the scope of every use
`ifndef GENETIC_MUTATION_ENGINE_ASSERT_SVH
`define GENETIC_MUTATION_ENGINE_ASSERT_SVH

// same-cycle implication, masked during reset
`define GME_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define GME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/gme_pkg.sv]
// shared types, codes and constants of the mutation engine
// no dependencies
package gme_pkg;

    localparam int CHROM_W    = 6;
    localparam int GENE_W     = 6;
    localparam int VALUE_W    = 8;
    localparam int POOL_AW    = CHROM_W + GENE_W;
    localparam int POOL_DEPTH = 1 << POOL_AW;
    localparam int HIST_AW    = 8;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int HIST_W     = 7;
    localparam int ALPHA_W    = 9;
    localparam int GCOUNT_W   = 7;
    localparam int DRAW_W     = 16;
    localparam int OP_W       = 3;

    localparam logic [ALPHA_W-1:0]  ALPHA_MAX  = 9'd256;
    localparam logic [GCOUNT_W-1:0] GENE_MAX   = 7'd64;
    localparam logic [VALUE_W-1:0]  VALUE_MASK = 8'hFF;
    localparam logic [DRAW_W-1:0]   LFSR_MASK  = 16'hB400;

    localparam logic [ALPHA_W-1:0]  RST_ALPHA   = 9'd16;
    localparam logic [GCOUNT_W-1:0] RST_GENES   = 7'd64;
    localparam logic [DRAW_W-1:0]   RST_THR_BLK = 16'd13107;
    localparam logic [DRAW_W-1:0]   RST_THR_INV = 16'd26214;
    localparam logic [DRAW_W-1:0]   RST_THR_SHF = 16'd39321;
    localparam logic [DRAW_W-1:0]   RST_THR_SWP = 16'd52428;
    localparam logic [DRAW_W-1:0]   RST_SEED    = 16'd44257;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_MUTATE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [OP_W-1:0] {
        OP_BLOCK   = 3'd0,
        OP_INVERSE = 3'd1,
        OP_SHUFFLE = 3'd2,
        OP_SWAP    = 3'd3,
        OP_CROSS   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        REG_ALPHA   = 3'd0,
        REG_GENES   = 3'd1,
        REG_THR_BLK = 3'd2,
        REG_THR_INV = 3'd3,
        REG_THR_SHF = 3'd4,
        REG_THR_SWP = 3'd5,
        REG_SEED    = 3'd6,
        REG_NONE    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]  alpha;
        logic [GCOUNT_W-1:0] genes;
        logic [DRAW_W-1:0]   thr_blk;
        logic [DRAW_W-1:0]   thr_inv;
        logic [DRAW_W-1:0]   thr_shf;
        logic [DRAW_W-1:0]   thr_swp;
        logic                seed_load;
        logic [DRAW_W-1:0]   seed;
    } cfg_t;

    function automatic logic [DRAW_W-1:0] lfsr_step(input logic [DRAW_W-1:0] s);
        logic [DRAW_W-1:0] sh;
        sh = s >> 1;
        return s[0] ? (sh ^ LFSR_MASK) : sh;
    endfunction

endpackage

[src/gme_ram.sv]
// generic single-write, single-read ram with registered read
// no dependencies
module gme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/gme_mod.sv]
// bit-serial remainder unit, one dividend bit per cycle
// depends on gme_pkg
module gme_mod (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [gme_pkg::DRAW_W-1:0]   dividend,
    input  logic [gme_pkg::ALPHA_W-1:0]  divisor,
    output logic                         busy,
    output logic                         done,
    output logic [gme_pkg::VALUE_W-1:0]  remainder
);

    logic [gme_pkg::DRAW_W-1:0]  num_reg;
    logic [gme_pkg::ALPHA_W-1:0] div_reg;
    logic [gme_pkg::ALPHA_W-1:0] rem_reg;
    logic [4:0]                  cnt_reg;
    logic                        done_reg;
    logic [gme_pkg::ALPHA_W:0]   trial;

    assign trial = {rem_reg, num_reg[gme_pkg::DRAW_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            num_reg  <= dividend;
            div_reg  <= divisor;
            rem_reg  <= '0;
            cnt_reg  <= 5'(gme_pkg::DRAW_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            num_reg  <= num_reg << 1;
            // remainder stays below the divisor, so it fits the narrower register
            if (trial >= {1'b0, div_reg}) begin
                rem_reg <= gme_pkg::ALPHA_W'(trial - {1'b0, div_reg});
            end else begin
                rem_reg <= gme_pkg::ALPHA_W'(trial);
            end
            cnt_reg  <= cnt_reg - 5'd1;
            done_reg <= (cnt_reg == 5'd1);
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign busy      = (cnt_reg != '0);
    assign done      = done_reg;
    assign remainder = rem_reg[gme_pkg::VALUE_W-1:0];

endmodule

[src/gme_regs.sv]
// apb configuration registers with clamped working values
// depends on gme_pkg
module gme_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output gme_pkg::cfg_t      cfg
);

    logic [gme_pkg::ALPHA_W-1:0]  alpha_reg;
    logic [gme_pkg::GCOUNT_W-1:0] genes_reg;
    logic [gme_pkg::DRAW_W-1:0]   thr_blk_reg;
    logic [gme_pkg::DRAW_W-1:0]   thr_inv_reg;
    logic [gme_pkg::DRAW_W-1:0]   thr_shf_reg;
    logic [gme_pkg::DRAW_W-1:0]   thr_swp_reg;
    logic [gme_pkg::DRAW_W-1:0]   seed_reg;
    logic                         wr_en;
    gme_pkg::reg_idx_t            idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = gme_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg   <= gme_pkg::RST_ALPHA;
            genes_reg   <= gme_pkg::RST_GENES;
            thr_blk_reg <= gme_pkg::RST_THR_BLK;
            thr_inv_reg <= gme_pkg::RST_THR_INV;
            thr_shf_reg <= gme_pkg::RST_THR_SHF;
            thr_swp_reg <= gme_pkg::RST_THR_SWP;
            seed_reg    <= gme_pkg::RST_SEED;
        end else if (wr_en) begin
            unique case (idx)
                gme_pkg::REG_ALPHA:   alpha_reg   <= pwdata[gme_pkg::ALPHA_W-1:0];
                gme_pkg::REG_GENES:   genes_reg   <= pwdata[gme_pkg::GCOUNT_W-1:0];
                gme_pkg::REG_THR_BLK: thr_blk_reg <= pwdata[gme_pkg::DRAW_W-1:0];
                gme_pkg::REG_THR_INV: thr_inv_reg <= pwdata[gme_pkg::DRAW_W-1:0];
                gme_pkg::REG_THR_SHF: thr_shf_reg <= pwdata[gme_pkg::DRAW_W-1:0];
                gme_pkg::REG_THR_SWP: thr_swp_reg <= pwdata[gme_pkg::DRAW_W-1:0];
                gme_pkg::REG_SEED:    seed_reg    <= pwdata[gme_pkg::DRAW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            gme_pkg::REG_ALPHA:   prdata = 32'(alpha_reg);
            gme_pkg::REG_GENES:   prdata = 32'(genes_reg);
            gme_pkg::REG_THR_BLK: prdata = 32'(thr_blk_reg);
            gme_pkg::REG_THR_INV: prdata = 32'(thr_inv_reg);
            gme_pkg::REG_THR_SHF: prdata = 32'(thr_shf_reg);
            gme_pkg::REG_THR_SWP: prdata = 32'(thr_swp_reg);
            gme_pkg::REG_SEED:    prdata = 32'(seed_reg);
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        // out-of-range settings clamp to the nearest legal value
        if (alpha_reg == '0) begin
            cfg.alpha = gme_pkg::ALPHA_W'(1);
        end else if (alpha_reg > gme_pkg::ALPHA_MAX) begin
            cfg.alpha = gme_pkg::ALPHA_MAX;
        end else begin
            cfg.alpha = alpha_reg;
        end
        if (genes_reg == '0) begin
            cfg.genes = gme_pkg::GCOUNT_W'(1);
        end else if (genes_reg > gme_pkg::GENE_MAX) begin
            cfg.genes = gme_pkg::GENE_MAX;
        end else begin
            cfg.genes = genes_reg;
        end
        cfg.thr_blk   = thr_blk_reg;
        cfg.thr_inv   = thr_inv_reg;
        cfg.thr_shf   = thr_shf_reg;
        cfg.thr_swp   = thr_swp_reg;
        cfg.seed_load = wr_en && (idx == gme_pkg::REG_SEED);
        cfg.seed      = (pwdata[gme_pkg::DRAW_W-1:0] == '0) ? gme_pkg::DRAW_W'(1)
                                                           : pwdata[gme_pkg::DRAW_W-1:0];
    end

endmodule

[src/genetic_mutation_engine.sv]
// top level: sequencer over the gene pool and value histogram memories
// depends on gme_pkg, gme_ram, gme_mod, gme_regs and the assertion header
//
//  channel  | handshake         | content
//  s_       | s_valid / s_ready | one command item: write, read or mutate
//  m_       | m_valid / m_ready | one result item per command
//  apb      | psel / penable    | seven configuration registers
//
// mutate: two serial remainders (a third for block fill), then the segment is
// filled gene by gene, reversed pair by pair, its ends swapped, copied from
// the neighbour chromosome gene by gene for crossover, or for shuffle a clear
// of alphabet_size histogram bins, a count of each gene and lfsr draws while
// sampling, all paced by the one-read, one-write pool and the remainder unit.
// reset is synchronous and needs no clearing pass. one item is worked at a
// time; a waiting result does not stop the next item being taken.
`include "genetic_mutation_engine_assert.svh"

module genetic_mutation_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [5:0]  s_chrom_index,
    input  logic [5:0]  s_gene_index,
    input  logic [7:0]  s_gene_value,
    input  logic [15:0] s_choice_draw,
    input  logic [15:0] s_pos_draw_a,
    input  logic [15:0] s_pos_draw_b,
    input  logic [15:0] s_value_draw,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_value,
    output logic [2:0]  m_operator_used,
    output logic [5:0]  m_range_low,
    output logic [5:0]  m_range_high,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_WAIT, ST_DIV_A, ST_DIV_B, ST_DIV_V, ST_FILL,
        ST_INV_A, ST_INV_B, ST_INV_C, ST_INV_D, ST_X_RD, ST_X_WR,
        ST_H_CLR, ST_C_RD, ST_C_MOD, ST_C_DIV, ST_C_HRD, ST_C_HWR,
        ST_S_STEP, ST_S_DIV, ST_S_HRD, ST_S_CHK, ST_DONE
    } state_t;

    gme_pkg::cfg_t cfg;

    state_t                         state_reg, state_next;
    logic [gme_pkg::CHROM_W-1:0]    chrom_reg, chrom_next;
    logic [gme_pkg::DRAW_W-1:0]     choice_reg, choice_next;
    logic [gme_pkg::DRAW_W-1:0]     db_reg, db_next;
    logic [gme_pkg::DRAW_W-1:0]     dv_reg, dv_next;
    logic [gme_pkg::GENE_W-1:0]     a_reg, a_next;
    logic [gme_pkg::GENE_W-1:0]     lo_reg, lo_next;
    logic [gme_pkg::GENE_W-1:0]     hi_reg, hi_next;
    logic [gme_pkg::GENE_W-1:0]     idx_reg, idx_next;
    logic [gme_pkg::GENE_W-1:0]     h_reg, h_next;
    gme_pkg::op_t                   op_reg, op_next;
    logic [gme_pkg::VALUE_W-1:0]    tmp_reg, tmp_next;
    logic [gme_pkg::VALUE_W-1:0]    rv_reg, rv_next;
    logic [gme_pkg::ALPHA_W-1:0]    clr_reg, clr_next;
    logic [gme_pkg::DRAW_W-1:0]     lfsr_reg, lfsr_next;
    logic                           m_valid_reg, m_valid_next;
    logic [7:0]                     m_rv_reg, m_rv_next;
    logic [2:0]                     m_op_reg, m_op_next;
    logic [5:0]                     m_lo_reg, m_lo_next;
    logic [5:0]                     m_hi_reg, m_hi_next;

    logic                           pool_we;
    logic [gme_pkg::POOL_AW-1:0]    pool_waddr, pool_raddr;
    logic [gme_pkg::VALUE_W-1:0]    pool_wdata, pool_rdata;
    logic                           hist_we;
    logic [gme_pkg::HIST_AW-1:0]    hist_waddr, hist_raddr;
    logic [gme_pkg::HIST_W-1:0]     hist_wdata, hist_rdata;

    logic                           div_start, div_busy, div_done;
    logic [gme_pkg::DRAW_W-1:0]     div_dividend;
    logic [gme_pkg::ALPHA_W-1:0]    div_divisor;
    logic [gme_pkg::VALUE_W-1:0]    div_rem;

    logic [gme_pkg::CHROM_W-1:0]    nb_chrom;
    logic [gme_pkg::GENE_W-1:0]     b_pos;
    logic [gme_pkg::DRAW_W-1:0]     lfsr_nx;

    gme_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    gme_ram #(.WIDTH(gme_pkg::VALUE_W), .DEPTH(gme_pkg::POOL_DEPTH)) u_pool (
        .aclk  (aclk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (pool_wdata),
        .raddr (pool_raddr),
        .rdata (pool_rdata)
    );

    gme_ram #(.WIDTH(gme_pkg::HIST_W), .DEPTH(gme_pkg::HIST_DEPTH)) u_hist (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    gme_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign pready   = 1'b1;
    assign s_ready  = (state_reg == ST_IDLE);
    assign nb_chrom = (chrom_reg != '0) ? chrom_reg - gme_pkg::CHROM_W'(1)
                                        : gme_pkg::CHROM_W'(1);
    assign b_pos    = div_rem[gme_pkg::GENE_W-1:0];
    assign lfsr_nx  = gme_pkg::lfsr_step(lfsr_reg);

    always_comb begin
        state_next   = state_reg;
        chrom_next   = chrom_reg;
        choice_next  = choice_reg;
        db_next      = db_reg;
        dv_next      = dv_reg;
        a_next       = a_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        idx_next     = idx_reg;
        h_next       = h_reg;
        op_next      = op_reg;
        tmp_next     = tmp_reg;
        rv_next      = rv_reg;
        clr_next     = clr_reg;
        lfsr_next    = lfsr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rv_next    = m_rv_reg;
        m_op_next    = m_op_reg;
        m_lo_next    = m_lo_reg;
        m_hi_next    = m_hi_reg;

        pool_we      = 1'b0;
        pool_waddr   = {chrom_reg, idx_reg};
        pool_wdata   = tmp_reg;
        pool_raddr   = {chrom_reg, idx_reg};
        hist_we      = 1'b0;
        hist_waddr   = tmp_reg;
        hist_wdata   = '0;
        hist_raddr   = tmp_reg;
        div_start    = 1'b0;
        div_dividend = dv_reg;
        div_divisor  = cfg.alpha;

        if (cfg.seed_load) begin
            lfsr_next = cfg.seed;
        end

        unique case (state_reg)
            ST_IDLE: begin
                pool_raddr = {s_chrom_index, s_gene_index};
                if (s_valid) begin
                    chrom_next  = s_chrom_index;
                    choice_next = s_choice_draw;
                    db_next     = s_pos_draw_b;
                    dv_next     = s_value_draw;
                    rv_next     = '0;
                    op_next     = gme_pkg::OP_BLOCK;
                    lo_next     = '0;
                    hi_next     = '0;
                    unique case (gme_pkg::kind_t'(s_kind))
                        gme_pkg::KIND_WRITE: begin
                            pool_we    = 1'b1;
                            pool_waddr = {s_chrom_index, s_gene_index};
                            pool_wdata = s_gene_value & gme_pkg::VALUE_MASK;
                            state_next = ST_DONE;
                        end
                        gme_pkg::KIND_READ: begin
                            state_next = ST_RD_WAIT;
                        end
                        gme_pkg::KIND_MUTATE: begin
                            div_start    = 1'b1;
                            div_dividend = s_pos_draw_a;
                            div_divisor  = gme_pkg::ALPHA_W'(cfg.genes);
                            state_next   = ST_DIV_A;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                rv_next    = pool_rdata;
                state_next = ST_DONE;
            end
            ST_DIV_A: begin
                if (div_done) begin
                    a_next       = div_rem[gme_pkg::GENE_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = db_reg;
                    div_divisor  = gme_pkg::ALPHA_W'(cfg.genes);
                    state_next   = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                if (div_done) begin
                    lo_next = (a_reg < b_pos) ? a_reg : b_pos;
                    hi_next = (a_reg < b_pos) ? b_pos : a_reg;
                    // first threshold that holds wins
                    if (choice_reg <= cfg.thr_blk) begin
                        op_next = gme_pkg::OP_BLOCK;
                    end else if (choice_reg <= cfg.thr_inv) begin
                        op_next = gme_pkg::OP_INVERSE;
                    end else if (choice_reg <= cfg.thr_shf) begin
                        op_next = gme_pkg::OP_SHUFFLE;
                    end else if (choice_reg <= cfg.thr_swp) begin
                        op_next = gme_pkg::OP_SWAP;
                    end else begin
                        op_next = gme_pkg::OP_CROSS;
                    end
                    idx_next = lo_next;
                    h_next   = hi_next;
                    case (op_next)
                        gme_pkg::OP_BLOCK: begin
                            div_start  = 1'b1;
                            state_next = ST_DIV_V;
                        end
                        gme_pkg::OP_INVERSE: begin
                            state_next = (lo_next < hi_next) ? ST_INV_A : ST_DONE;
                        end
                        gme_pkg::OP_SWAP:    state_next = ST_INV_A;
                        gme_pkg::OP_SHUFFLE: begin
                            clr_next   = '0;
                            state_next = ST_H_CLR;
                        end
                        default:             state_next = ST_X_RD;
                    endcase
                end
            end
            ST_DIV_V: begin
                if (div_done) begin
                    tmp_next   = div_rem & gme_pkg::VALUE_MASK;
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                pool_we = 1'b1;
                if (idx_reg == hi_reg) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + gme_pkg::GENE_W'(1);
                end
            end
            ST_INV_A: begin
                state_next = ST_INV_B;
            end
            ST_INV_B: begin
                pool_raddr = {chrom_reg, h_reg};
                tmp_next   = pool_rdata;
                state_next = ST_INV_C;
            end
            ST_INV_C: begin
                pool_we    = 1'b1;
                pool_wdata = pool_rdata;
                state_next = ST_INV_D;
            end
            ST_INV_D: begin
                pool_we    = 1'b1;
                pool_waddr = {chrom_reg, h_reg};
                if (op_reg == gme_pkg::OP_SWAP) begin
                    state_next = ST_DONE;
                end else if ((idx_reg + gme_pkg::GENE_W'(1)) < (h_reg - gme_pkg::GENE_W'(1)))
                begin
                    idx_next   = idx_reg + gme_pkg::GENE_W'(1);
                    h_next     = h_reg - gme_pkg::GENE_W'(1);
                    state_next = ST_INV_A;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_X_RD: begin
                pool_raddr = {nb_chrom, idx_reg};
                state_next = ST_X_WR;
            end
            ST_X_WR: begin
                pool_we    = 1'b1;
                pool_wdata = pool_rdata;
                if (idx_reg == hi_reg) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + gme_pkg::GENE_W'(1);
                    state_next = ST_X_RD;
                end
            end
            ST_H_CLR: begin
                // only bins below the alphabet are ever read back
                hist_we    = 1'b1;
                hist_waddr = clr_reg[gme_pkg::HIST_AW-1:0];
                if ((clr_reg + gme_pkg::ALPHA_W'(1)) == cfg.alpha) begin
                    state_next = ST_C_RD;
                end else begin
                    clr_next = clr_reg + gme_pkg::ALPHA_W'(1);
                end
            end
            ST_C_RD: begin
                state_next = ST_C_MOD;
            end
            ST_C_MOD: begin
                div_start    = 1'b1;
                div_dividend = gme_pkg::DRAW_W'(pool_rdata);
                state_next   = ST_C_DIV;
            end
            ST_C_DIV: begin
                if (div_done) begin
                    tmp_next   = div_rem;
                    state_next = ST_C_HRD;
                end
            end
            ST_C_HRD: begin
                state_next = ST_C_HWR;
            end
            ST_C_HWR: begin
                hist_we    = 1'b1;
                hist_wdata = hist_rdata + gme_pkg::HIST_W'(1);
                if (idx_reg == hi_reg) begin
                    idx_next   = lo_reg;
                    state_next = ST_S_STEP;
                end else begin
                    idx_next   = idx_reg + gme_pkg::GENE_W'(1);
                    state_next = ST_C_RD;
                end
            end
            ST_S_STEP: begin
                lfsr_next    = lfsr_nx;
                div_start    = 1'b1;
                div_dividend = lfsr_nx;
                state_next   = ST_S_DIV;
            end
            ST_S_DIV: begin
                if (div_done) begin
                    tmp_next   = div_rem;
                    state_next = ST_S_HRD;
                end
            end
            ST_S_HRD: begin
                state_next = ST_S_CHK;
            end
            ST_S_CHK: begin
                // rejected draws go round again with a fresh lfsr value
                if (hist_rdata != '0) begin
                    hist_we    = 1'b1;
                    hist_wdata = hist_rdata - gme_pkg::HIST_W'(1);
                    pool_we    = 1'b1;
                    pool_wdata = tmp_reg & gme_pkg::VALUE_MASK;
                    if (idx_reg == hi_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = idx_reg + gme_pkg::GENE_W'(1);
                        state_next = ST_S_STEP;
                    end
                end else begin
                    state_next = ST_S_STEP;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rv_next    = rv_reg;
                    m_op_next    = op_reg;
                    m_lo_next    = lo_reg;
                    m_hi_next    = hi_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lfsr_reg    <= gme_pkg::RST_SEED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lfsr_reg    <= lfsr_next;
            m_valid_reg <= m_valid_next;
        end
        chrom_reg  <= chrom_next;
        choice_reg <= choice_next;
        db_reg     <= db_next;
        dv_reg     <= dv_next;
        a_reg      <= a_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        h_reg      <= h_next;
        op_reg     <= op_next;
        tmp_reg    <= tmp_next;
        rv_reg     <= rv_next;
        clr_reg    <= clr_next;
        m_rv_reg   <= m_rv_next;
        m_op_reg   <= m_op_next;
        m_lo_reg   <= m_lo_next;
        m_hi_reg   <= m_hi_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_read_value    = m_rv_reg;
    assign m_operator_used = m_op_reg;
    assign m_range_low     = m_lo_reg;
    assign m_range_high    = m_hi_reg;

    `GME_ASSERT_NEXT(a_one_item_at_a_time, s_valid && s_ready, !s_ready, "item taken while busy")
    `GME_ASSERT_SAME(a_mod_start_idle, div_start, !div_busy, "remainder unit restarted while busy")
    `GME_ASSERT_SAME(a_walk_in_segment, state_reg == ST_FILL || state_reg == ST_X_WR,
                     (idx_reg >= lo_reg) && (idx_reg <= hi_reg), "gene walk left the segment")
    `GME_ASSERT_SAME(a_sample_from_bin, pool_we && state_reg == ST_S_CHK, hist_rdata != '0,
                     "shuffle wrote a value with an empty bin")

endmodule

[tb/genetic_mutation_engine_test.sv]
// self-checking test of genetic_mutation_engine: directed and random items, apb config phases
// depends on gme_pkg and the rtl under src; holds its own prediction of the gene pool
module genetic_mutation_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 400000;

    typedef struct {
        gme_pkg::kind_t kind;
        logic [5:0]     chrom;
        logic [5:0]     gene;
        logic [7:0]     value;
        logic [15:0]    choice;
        logic [15:0]    draw_a;
        logic [15:0]    draw_b;
        logic [15:0]    draw_v;
    } command_t;

    typedef struct {
        logic [7:0]   read_value;
        gme_pkg::op_t op;
        logic [5:0]   lo;
        logic [5:0]   hi;
    } outcome_t;

    class mutation_scoreboard;
        logic [7:0]  pool [4096];
        int unsigned counts [256];
        logic [15:0] lfsr;
        int unsigned alpha_reg, genes_reg, seed_reg;
        int unsigned thr [4];
        outcome_t    expected_q [$];
        int          errors;

        function new();
            alpha_reg = gme_pkg::RST_ALPHA;
            genes_reg = gme_pkg::RST_GENES;
            thr[0] = gme_pkg::RST_THR_BLK;
            thr[1] = gme_pkg::RST_THR_INV;
            thr[2] = gme_pkg::RST_THR_SHF;
            thr[3] = gme_pkg::RST_THR_SWP;
            set_reg(gme_pkg::REG_SEED, gme_pkg::RST_SEED);
            errors = 0;
            foreach (pool[i]) pool[i] = '0;
        endfunction

        function void set_reg(gme_pkg::reg_idx_t r, int unsigned v);
            case (r)
                gme_pkg::REG_ALPHA:   alpha_reg = v & 'h1FF;
                gme_pkg::REG_GENES:   genes_reg = v & 'h7F;
                gme_pkg::REG_THR_BLK: thr[0] = v & 'hFFFF;
                gme_pkg::REG_THR_INV: thr[1] = v & 'hFFFF;
                gme_pkg::REG_THR_SHF: thr[2] = v & 'hFFFF;
                gme_pkg::REG_THR_SWP: thr[3] = v & 'hFFFF;
                gme_pkg::REG_SEED: begin
                    seed_reg = v & 'hFFFF;
                    lfsr = (seed_reg == 0) ? 16'd1 : seed_reg[15:0];
                end
                default: ;
            endcase
        endfunction

        // rejection sample against the histogram, lowest nonzero bin as a guard
        function int unsigned pick_value(int unsigned alpha);
            int unsigned v;
            for (int k = 0; k < 65536; k++) begin
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ 16'hB400) : (lfsr >> 1);
                v = lfsr % alpha;
                if (counts[v] != 0) return v;
            end
            for (v = 0; v < alpha; v++)
                if (counts[v] != 0) return v;
            return 0;
        endfunction

        function void note_item(command_t c);
            outcome_t    r;
            int unsigned base, nbase, g, alpha, a, b, lo, hi, x, l, h;
            logic [7:0]  t;
            r = '{8'd0, gme_pkg::OP_BLOCK, 6'd0, 6'd0};
            base = c.chrom * 64;
            case (c.kind)
                gme_pkg::KIND_WRITE: pool[base + c.gene] = c.value;
                gme_pkg::KIND_READ:  r.read_value = pool[base + c.gene];
                gme_pkg::KIND_MUTATE: begin
                    g = (genes_reg == 0) ? 1 : (genes_reg > 64 ? 64 : genes_reg);
                    alpha = (alpha_reg == 0) ? 1 : (alpha_reg > 256 ? 256 : alpha_reg);
                    a = c.draw_a % g;
                    b = c.draw_b % g;
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                    r.lo = 6'(lo);
                    r.hi = 6'(hi);
                    if (c.choice <= thr[0]) r.op = gme_pkg::OP_BLOCK;
                    else if (c.choice <= thr[1]) r.op = gme_pkg::OP_INVERSE;
                    else if (c.choice <= thr[2]) r.op = gme_pkg::OP_SHUFFLE;
                    else if (c.choice <= thr[3]) r.op = gme_pkg::OP_SWAP;
                    else r.op = gme_pkg::OP_CROSS;
                    case (r.op)
                        gme_pkg::OP_BLOCK:
                            for (int i = lo; i <= hi; i++)
                                pool[base + i] = 8'(c.draw_v % alpha);
                        gme_pkg::OP_INVERSE: begin
                            l = lo;
                            h = hi;
                            while (l < h) begin
                                t = pool[base + l];
                                pool[base + l] = pool[base + h];
                                pool[base + h] = t;
                                l++;
                                h--;
                            end
                        end
                        gme_pkg::OP_SHUFFLE: begin
                            foreach (counts[i]) counts[i] = 0;
                            for (int i = lo; i <= hi; i++) counts[pool[base + i] % alpha]++;
                            for (int i = lo; i <= hi; i++) begin
                                x = pick_value(alpha);
                                pool[base + i] = 8'(x);
                                if (counts[x] != 0) counts[x]--;
                            end
                        end
                        gme_pkg::OP_SWAP: begin
                            t = pool[base + lo];
                            pool[base + lo] = pool[base + hi];
                            pool[base + hi] = t;
                        end
                        default: begin
                            nbase = ((c.chrom != 0) ? c.chrom - 1 : 1) * 64;
                            for (int i = lo; i <= hi; i++) pool[base + i] = pool[nbase + i];
                        end
                    endcase
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(outcome_t got);
            outcome_t want;
            if (expected_q.size() == 0) begin
                report("unexpected item", 1, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.read_value !== want.read_value)
                report("read_value", got.read_value, want.read_value);
            if (got.op !== want.op) report("operator_used", got.op, want.op);
            if (got.lo !== want.lo) report("range_low", got.lo, want.lo);
            if (got.hi !== want.hi) report("range_high", got.hi, want.hi);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid, s_ready;
    logic [1:0]  s_kind;
    logic [5:0]  s_chrom_index, s_gene_index;
    logic [7:0]  s_gene_value;
    logic [15:0] s_choice_draw, s_pos_draw_a, s_pos_draw_b, s_value_draw;
    logic        m_valid, m_ready;
    logic [7:0]  m_read_value;
    logic [2:0]  m_operator_used;
    logic [5:0]  m_range_low, m_range_high;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    mutation_scoreboard pool_sb = new();
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int quiet_cycles = 0;
    // chromosomes fully written at start; neighbours of the mutated ones are in here too
    int unsigned loaded [6] = '{0, 1, 2, 3, 62, 63};
    int unsigned mutable [5] = '{0, 1, 2, 3, 63};

    genetic_mutation_engine dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pool_sb.check_result('{m_read_value, gme_pkg::op_t'(m_operator_used), m_range_low,
                m_range_high});
    end

    // watchdog on cycles with no item moving and no apb access
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold when asked
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                m_ready = 1'b0;
                hold_taken = 1'b1;
                repeat (3000) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge aclk);
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input command_t c);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_kind = c.kind;
        s_chrom_index = c.chrom;
        s_gene_index = c.gene;
        s_gene_value = c.value;
        s_choice_draw = c.choice;
        s_pos_draw_a = c.draw_a;
        s_pos_draw_b = c.draw_b;
        s_value_draw = c.draw_v;
        do @(posedge aclk); while (!s_ready);
        pool_sb.note_item(c);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pool_sb.expected_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(input gme_pkg::reg_idx_t r, input int unsigned v);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 5'(r * 4);
        pwdata = v;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        pool_sb.set_reg(r, v);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic command_t make_item(gme_pkg::kind_t k, int unsigned ch, int unsigned ge,
                                           int unsigned va, int unsigned cd, int unsigned da,
                                           int unsigned db, int unsigned dv);
        command_t c;
        c = '{k, 6'(ch), 6'(ge), 8'(va), 16'(cd), 16'(da), 16'(db), 16'(dv)};
        return c;
    endfunction

    function automatic command_t random_item();
        command_t    c;
        int unsigned sel, t;
        c = make_item(gme_pkg::KIND_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
            $urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom_range(0, 65535));
        sel = $urandom_range(0, 99);
        if (sel < 22) begin
            c.kind = gme_pkg::KIND_WRITE;
        end else if (sel < 40) begin
            c.kind = gme_pkg::KIND_READ;
            c.chrom = loaded[$urandom_range(0, 5)];
        end else if (sel < 95) begin
            c.kind = gme_pkg::KIND_MUTATE;
            c.chrom = mutable[$urandom_range(0, 4)];
            // aim at the threshold boundaries half the time
            if ($urandom_range(0, 1)) begin
                t = pool_sb.thr[$urandom_range(0, 3)];
                c.choice = 16'(t + $urandom_range(0, 1));
            end
        end else begin
            c.kind = gme_pkg::KIND_NONE;
        end
        return c;
    endfunction

    task automatic run_phase(int unsigned alpha, int unsigned genes, int unsigned tb,
                             int unsigned ti, int unsigned ts, int unsigned tw,
                             int unsigned seed, int n);
        drain();
        apb_write(gme_pkg::REG_ALPHA, alpha);
        apb_write(gme_pkg::REG_GENES, genes);
        apb_write(gme_pkg::REG_THR_BLK, tb);
        apb_write(gme_pkg::REG_THR_INV, ti);
        apb_write(gme_pkg::REG_THR_SHF, ts);
        apb_write(gme_pkg::REG_THR_SWP, tw);
        apb_write(gme_pkg::REG_SEED, seed);
        repeat (n) send_item(random_item());
    endtask

    initial begin
        command_t directed [$];
        aresetn = 1'b0;
        s_valid = 1'b0;
        {s_kind, s_chrom_index, s_gene_index, s_gene_value} = '0;
        {s_choice_draw, s_pos_draw_a, s_pos_draw_b, s_value_draw} = '0;
        {psel, penable, pwrite, paddr, pwdata} = '0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // fill the chromosomes that later reads and mutations touch
        foreach (loaded[k])
            for (int g = 0; g < 64; g++)
                send_item(make_item(gme_pkg::KIND_WRITE, loaded[k], g, $urandom_range(0, 255),
                    0, 0, 0, 0));

        directed.push_back(make_item(gme_pkg::KIND_WRITE, 63, 63, 255, 65535, 65535, 65535,
            65535));
        directed.push_back(make_item(gme_pkg::KIND_READ, 63, 63, 0, 0, 0, 0, 0));
        directed.push_back(make_item(gme_pkg::KIND_READ, 0, 0, 255, 0, 0, 0, 0));
        directed.push_back(make_item(gme_pkg::KIND_NONE, 63, 63, 255, 65535, 65535, 65535,
            65535));
        directed.push_back(make_item(gme_pkg::KIND_MUTATE, 0, 0, 0, 0, 0, 65535, 65535));
        directed.push_back(make_item(gme_pkg::KIND_MUTATE, 1, 0, 0, 13107, 63, 0, 3));
        directed.push_back(make_item(gme_pkg::KIND_MUTATE, 2, 0, 0, 13108, 5, 40, 0));
        directed.push_back(make_item(gme_pkg::KIND_MUTATE, 3, 0, 0, 26214, 7, 7, 0));
        directed.push_back(make_item(gme_pkg::KIND_MUTATE, 63, 0, 0, 26215, 0, 63, 0));
        directed.push_back(make_item(gme_pkg::KIND_MUTATE, 1, 0, 0, 39321, 10, 30, 0));
        directed.push_back(make_item(gme_pkg::KIND_MUTATE, 2, 0, 0, 39322, 0, 63, 0));
        directed.push_back(make_item(gme_pkg::KIND_MUTATE, 3, 0, 0, 52428, 2, 2, 0));
        directed.push_back(make_item(gme_pkg::KIND_MUTATE, 0, 0, 0, 52429, 0, 63, 0));
        directed.push_back(make_item(gme_pkg::KIND_MUTATE, 63, 0, 0, 65535, 65535, 64, 0));
        directed.push_back(make_item(gme_pkg::KIND_READ, 63, 10, 0, 0, 0, 0, 0));
        directed.push_back(make_item(gme_pkg::KIND_READ, 0, 40, 0, 0, 0, 0, 0));
        foreach (directed[i]) send_item(directed[i]);

        // long receiver hold while the next phase keeps offering items
        drain();
        hold_req = 1'b1;
        run_phase(2, 64, 13107, 26214, 39321, 52428, 0, 150);
        run_phase(256, 4, 40000, 20000, 60000, 65535, 65535, 150);
        run_phase(0, 0, 0, 16384, 32768, 49152, 1, 150);
        run_phase(511, 8, 65535, 65535, 65535, 65535, 777, 100);
        run_phase(5, 127, 13107, 26214, 39321, 52428, 4321, 150);
        drain();
        idle_on = 1'b0;
        run_phase(7, 20, 0, 0, 32768, 40000, 12345, 150);

        drain();
        repeat (50) @(posedge aclk);
        if (pool_sb.errors == 0 && pool_sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
